@@ design/ehptr_pkg.sv @@
package ehptr_pkg;

  localparam int unsigned QueueDepth = 2;

  localparam logic [7:0] ENC_OMIT = 8'hFF;

  localparam logic [3:0] FMT_ABSPTR = 4'h0;
  localparam logic [3:0] FMT_ULEB   = 4'h1;
  localparam logic [3:0] FMT_UDATA2 = 4'h2;
  localparam logic [3:0] FMT_UDATA4 = 4'h3;
  localparam logic [3:0] FMT_UDATA8 = 4'h4;
  localparam logic [3:0] FMT_SLEB   = 4'h9;
  localparam logic [3:0] FMT_SDATA2 = 4'hA;
  localparam logic [3:0] FMT_SDATA4 = 4'hB;
  localparam logic [3:0] FMT_SDATA8 = 4'hC;

  localparam logic [2:0] APP_ABS   = 3'd0;
  localparam logic [2:0] APP_PCREL = 3'd1;

  localparam logic [6:0] LEB_SHIFT_MAX = 7'd70;
  localparam logic [3:0] COUNT_MAX     = 4'hF;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_BAD_FMT = 2'd1,
    ST_BAD_APP = 2'd2,
    ST_OMIT    = 2'd3
  } status_e;

  typedef struct packed {
    logic [7:0]  data_byte;
    logic [63:0] byte_addr;
  } in_item_t;

  typedef struct packed {
    logic [63:0] value;
    logic [3:0]  bytes_used;
    logic [1:0]  status;
    logic        needs_indirect;
  } out_item_t;

  // Classified byte handed from front to back
  typedef struct packed {
    status_e     op;
    logic [3:0]  fmt;
    logic        pcrel;
    logic        indirect;
    logic [7:0]  data_byte;
    logic [63:0] byte_addr;
  } q_entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  function automatic logic fmt_valid(logic [3:0] fmt);
    logic ok;
    unique case (fmt) inside
      FMT_ABSPTR, FMT_ULEB, FMT_UDATA2, FMT_UDATA4, FMT_UDATA8,
      FMT_SLEB, FMT_SDATA2, FMT_SDATA4, FMT_SDATA8: ok = 1'b1;
      default: ok = 1'b0;
    endcase
    return ok;
  endfunction

  // Byte length of a fixed-size format; zero for LEB128
  function automatic logic [3:0] fixed_len(logic [3:0] fmt);
    logic [3:0] len;
    unique case (fmt) inside
      FMT_ABSPTR, FMT_UDATA8, FMT_SDATA8: len = 4'd8;
      FMT_UDATA2, FMT_SDATA2:             len = 4'd2;
      FMT_UDATA4, FMT_SDATA4:             len = 4'd4;
      default:                            len = 4'd0;
    endcase
    return len;
  endfunction

endpackage

@@ design/eh_encoded_pointer_decoder_core.sv @@
// Channel  Direction  Handshake          Payload
// in       input      in_valid/in_stall   in_item_i  (data_byte, byte_addr)
// out      output     out_valid/out_stall out_item_o (value, bytes_used, status, ...)
// cfg      input      cfg_valid/cfg_ready cfg_data_i (ptr_encoding)
//
// One byte enters per cycle while the queue is not full. A result is registered in
// the output register once the byte ending its value has passed through the
// queue to the decoder, which retires one queued byte per cycle unless stalled.
// Reset sets the encoding to omit and empties the queue and the output register.
// The input stalls only when the queue is full; the decoder stalls only when a
// result sits in the output register and the consumer holds out_stall_i.
module eh_encoded_pointer_decoder_core import ehptr_pkg::*; #(
  parameter int unsigned QDepth = QueueDepth
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  in_item_t   in_item_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output out_item_t  out_item_o,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [7:0] cfg_data_i
);

  q_stat_t  q_stat;
  q_entry_t push_entry, head_entry;
  logic     push, pop, cfg_clr;

  ehptr_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .cfg_clr_o   (cfg_clr),
    .q_stat_i    (q_stat),
    .push_o      (push),
    .entry_o     (push_entry)
  );

  ehptr_fifo #(
    .Depth (QDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (push_entry),
    .pop_i   (pop),
    .stat_o  (q_stat),
    .entry_o (head_entry)
  );

  ehptr_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_clr_i   (cfg_clr),
    .q_stat_i    (q_stat),
    .entry_i     (head_entry),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(q_stat.full && q_stat.empty))
    else $error("queue reports full and empty");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_item_o.status == ST_OK) |-> (out_item_o.bytes_used != 4'd0))
    else $error("ok result with no bytes used");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_item_o.status != ST_OK) |->
      (out_item_o.value == 64'd0 && out_item_o.bytes_used == 4'd0 &&
       !out_item_o.needs_indirect))
    else $error("error result carries data");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> !q_stat.empty)
    else $error("accepted item missing from queue");

endmodule

@@ design/ehptr_front.sv @@
module ehptr_front import ehptr_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_item_i,
  input  logic      cfg_valid_i,
  output logic      cfg_ready_o,
  input  logic [7:0] cfg_data_i,
  output logic      cfg_clr_o,
  input  q_stat_t   q_stat_i,
  output logic      push_o,
  output q_entry_t  entry_o
);

  logic [7:0] enc_q;
  logic [3:0] fmt;
  logic [2:0] app;
  status_e    op;

  assign cfg_ready_o = 1'b1;
  assign cfg_clr_o   = cfg_valid_i & cfg_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enc_q <= ENC_OMIT;
    end else if (cfg_clr_o) begin
      enc_q <= cfg_data_i;
    end
  end

  assign fmt = enc_q[3:0];
  assign app = enc_q[6:4];

  // Format is checked before application
  always_comb begin
    if (enc_q == ENC_OMIT) begin
      op = ST_OMIT;
    end else if (!fmt_valid(fmt)) begin
      op = ST_BAD_FMT;
    end else if (app != APP_ABS && app != APP_PCREL) begin
      op = ST_BAD_APP;
    end else begin
      op = ST_OK;
    end
  end

  assign in_stall_o = q_stat_i.full;
  assign push_o     = in_valid_i & ~q_stat_i.full;

  always_comb begin
    entry_o.op        = op;
    entry_o.fmt       = fmt;
    entry_o.pcrel     = (app == APP_PCREL);
    entry_o.indirect  = enc_q[7];
    entry_o.data_byte = in_item_i.data_byte;
    entry_o.byte_addr = in_item_i.byte_addr;
  end

endmodule

@@ design/ehptr_fifo.sv @@
module ehptr_fifo import ehptr_pkg::*; #(
  parameter int unsigned Depth = QueueDepth
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_i,
  input  q_entry_t entry_i,
  input  logic     pop_i,
  output q_stat_t  stat_o,
  output q_entry_t entry_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(Depth);

  q_entry_t          mem_q [Depth];
  logic [PtrW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic              do_push, do_pop;

  assign stat_o.full  = (cnt_q == CntFull);
  assign stat_o.empty = (cnt_q == '0);
  assign do_push = push_i & ~stat_o.full;
  assign do_pop  = pop_i & ~stat_o.empty;
  assign entry_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

endmodule

@@ design/ehptr_back.sv @@
module ehptr_back import ehptr_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      cfg_clr_i,
  input  q_stat_t   q_stat_i,
  input  q_entry_t  entry_i,
  output logic      pop_o,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_item_o
);

  logic [63:0] acc_q, acc_d;
  logic [6:0]  shift_q, shift_d;
  logic [3:0]  cnt_q, cnt_d;
  logic [63:0] start_q, start_d;
  logic        in_field_q;
  logic        out_valid_q;
  out_item_t   out_q, res;

  logic [63:0] base_acc, base_start, fix_bits, leb_bits, sum;
  logic [6:0]  base_shift, shift_sum;
  logic [3:0]  base_cnt, len;
  logic        is_leb, done, emit;

  assign pop_o = ~q_stat_i.empty & (~out_valid_q | ~out_stall_i);

  always_comb begin
    base_acc   = in_field_q ? acc_q   : '0;
    base_shift = in_field_q ? shift_q : '0;
    base_cnt   = in_field_q ? cnt_q   : '0;
    base_start = in_field_q ? start_q : entry_i.byte_addr;
    cnt_d      = (base_cnt == COUNT_MAX) ? COUNT_MAX : base_cnt + 4'd1;
    is_leb     = (entry_i.fmt == FMT_ULEB) || (entry_i.fmt == FMT_SLEB);
    len        = fixed_len(entry_i.fmt);
    fix_bits   = {56'd0, entry_i.data_byte} << base_shift[5:0];
    leb_bits   = {57'd0, entry_i.data_byte[6:0]} << base_shift[5:0];
    start_d    = base_start;
    acc_d      = base_acc;
    shift_sum  = '0;
    if (is_leb) begin
      // drop payload bits at or beyond bit 64
      if (!base_shift[6]) begin
        acc_d = base_acc | leb_bits;
      end
      shift_sum = base_shift + 7'd7;
      shift_d   = (shift_sum > LEB_SHIFT_MAX) ? LEB_SHIFT_MAX : shift_sum;
      done      = ~entry_i.data_byte[7];
      if (done && entry_i.fmt == FMT_SLEB && entry_i.data_byte[6] && !shift_d[6]) begin
        acc_d = acc_d | (~64'd0 << shift_d[5:0]);
      end
    end else begin
      if (!base_shift[6]) begin
        acc_d = base_acc | fix_bits;
      end
      shift_d = base_shift + 7'd8;
      done    = (cnt_d >= len);
      if (done && entry_i.fmt == FMT_SDATA2 && acc_d[15]) begin
        acc_d[63:16] = '1;
      end else if (done && entry_i.fmt == FMT_SDATA4 && acc_d[31]) begin
        acc_d[63:32] = '1;
      end
    end
    sum  = acc_d + (entry_i.pcrel ? base_start : 64'd0);
    emit = (entry_i.op != ST_OK) || done;
    if (entry_i.op != ST_OK) begin
      res.value          = '0;
      res.bytes_used     = '0;
      res.status         = entry_i.op;
      res.needs_indirect = 1'b0;
    end else begin
      res.value          = sum;
      res.bytes_used     = cnt_d;
      res.status         = ST_OK;
      res.needs_indirect = entry_i.indirect;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_field_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_clr_i) begin
        in_field_q <= 1'b0;
      end else if (pop_o) begin
        in_field_q <= ~emit;
      end
      if (pop_o && emit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      acc_q   <= acc_d;
      shift_q <= shift_d;
      cnt_q   <= cnt_d;
      start_q <= start_d;
    end
    if (pop_o && emit) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule
